[hdl/bhq_pkg.sv]
// Shared types and codes for the binary min-heap queue.
// Used by the channel interfaces, the storage cell and the top level.
package bhq_pkg;

  localparam int KEY_W = 64;

  typedef logic [KEY_W-1:0] key_t;

  localparam logic FN_PUSH = 1'b0;
  localparam logic FN_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Operation broadcast to every cell at once.
  typedef struct packed {
    logic push;
    logic pop;
    key_t key;
  } cmd_t;

endpackage

[hdl/bhq_if.sv]
// Valid/ready channel interfaces for the binary min-heap queue.
// Depends on bhq_pkg for the key and status types.
interface bhq_in_if;
  import bhq_pkg::*;

  logic valid;
  logic ready;
  logic func;
  key_t key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

interface bhq_out_if #(
  parameter int CNT_W = 9
);
  import bhq_pkg::*;

  logic             valid;
  logic             ready;
  key_t             popped_key;
  status_t          status;
  key_t             top_key;
  logic             top_valid;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, output popped_key, output status, output top_key,
                  output top_valid, output entry_count, input ready);
  modport sink   (input valid, input popped_key, input status, input top_key,
                  input top_valid, input entry_count, output ready);
endinterface

[hdl/bhq_cell.sv]
// One slot of the sorted key chain: holds a key and its valid flag.
// Depends on bhq_pkg; neighbors exchange keys to insert or remove in place.
module bhq_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  bhq_pkg::cmd_t cmd,
  input  bhq_pkg::key_t left_key,
  input  logic          left_vld,
  input  logic          left_le,
  input  bhq_pkg::key_t right_key,
  input  logic          right_vld,
  output bhq_pkg::key_t key,
  output logic          vld,
  output logic          le
);
  import bhq_pkg::*;

  key_t key_r;
  key_t key_nxt;
  logic vld_r;
  logic vld_nxt;
  logic le_w;

  // A valid key not above the incoming key stays; the chain stays sorted.
  assign le_w = vld_r && (key_r <= cmd.key);

  always_comb begin
    key_nxt = key_r;
    vld_nxt = vld_r;
    if (cmd.push) begin
      if (!le_w) begin
        if (left_le) begin
          key_nxt = cmd.key;
          vld_nxt = 1'b1;
        end else begin
          key_nxt = left_key;
          vld_nxt = left_vld;
        end
      end
    end else if (cmd.pop) begin
      key_nxt = right_key;
      vld_nxt = right_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key = key_r;
  assign vld = vld_r;
  assign le  = le_w;

endmodule

[hdl/binary_min_heap_queue.sv]
// Top level of the min-priority queue: a sorted chain of key cells plus count.
// Depends on bhq_pkg, the channel interfaces in bhq_if and bhq_cell.
//
//   channel   dir   payload                                             handshake
//   in_ch     in    func, key                                           valid/ready
//   out_ch    out   popped_key, status, top_key, top_valid, entry_count valid/ready
//
// For each item, all cells compare against the key at once and shift
// one place toward or away from the head, and the result lands in an output register.
// A new item is taken in the cycle its result register is free or being emptied.
// A stalled result blocks further items; reset is synchronous and empties the queue.
module binary_min_heap_queue #(
  parameter int CAPACITY = 256
) (
  input logic      clk,
  input logic      rst_n,
  bhq_in_if.sink   in_ch,
  bhq_out_if.source out_ch
);
  import bhq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  key_t             cell_key [CAPACITY];
  logic             cell_vld [CAPACITY];
  logic             cell_le  [CAPACITY];

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_vld_r;
  key_t             popped_r;
  status_t          status_r;
  key_t             top_r;
  logic             top_vld_r;
  logic [CNT_W-1:0] count_r;

  logic             accept;
  logic             is_empty;
  logic             is_full;
  cmd_t             cmd;
  key_t             popped_nxt;
  status_t          status_nxt;
  key_t             top_nxt;

  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_empty    = (cnt_r == '0);
  assign is_full     = (cnt_r == CNT_W'(CAPACITY));

  always_comb begin
    cmd.push   = accept && (in_ch.func == FN_PUSH) && !is_full;
    cmd.pop    = accept && (in_ch.func == FN_POP) && !is_empty;
    cmd.key    = in_ch.key;
    cnt_nxt    = cnt_r;
    popped_nxt = '0;
    status_nxt = ST_OK;
    top_nxt    = is_empty ? '0 : cell_key[0];
    if (in_ch.func == FN_PUSH) begin
      if (is_full) begin
        status_nxt = ST_FULL;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (is_empty || (in_ch.key < cell_key[0])) begin
          top_nxt = in_ch.key;
        end
      end
    end else begin
      if (is_empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        cnt_nxt    = cnt_r - 1'b1;
        popped_nxt = cell_key[0];
        top_nxt    = cell_vld[1] ? cell_key[1] : '0;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t left_key;
    logic left_vld;
    logic left_le;
    key_t right_key;
    logic right_vld;

    if (i == 0) begin : g_head
      assign left_key = '0;
      assign left_vld = 1'b0;
      assign left_le  = 1'b1;
    end else begin : g_body
      assign left_key = cell_key[i-1];
      assign left_vld = cell_vld[i-1];
      assign left_le  = cell_le[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = '0;
      assign right_vld = 1'b0;
    end else begin : g_mid
      assign right_key = cell_key[i+1];
      assign right_vld = cell_vld[i+1];
    end

    bhq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_key  (left_key),
      .left_vld  (left_vld),
      .left_le   (left_le),
      .right_key (right_key),
      .right_vld (right_vld),
      .key       (cell_key[i]),
      .vld       (cell_vld[i]),
      .le        (cell_le[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r     <= cnt_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r  <= popped_nxt;
      status_r  <= status_nxt;
      top_r     <= top_nxt;
      top_vld_r <= (cnt_nxt != '0);
      count_r   <= cnt_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.popped_key  = popped_r;
  assign out_ch.status      = status_r;
  assign out_ch.top_key     = top_r;
  assign out_ch.top_valid   = top_vld_r;
  assign out_ch.entry_count = count_r;

  a_head_matches_count : assert property (@(posedge clk) disable iff (!rst_n)
    cell_vld[0] == (cnt_r != '0))
    else $error("head cell valid flag disagrees with the count");

  a_valid_prefix : assert property (@(posedge clk) disable iff (!rst_n)
    cell_vld[1] |-> cell_vld[0])
    else $error("second cell holds a key while the head is empty");

  a_head_is_min : assert property (@(posedge clk) disable iff (!rst_n)
    cell_vld[1] |-> (cell_key[0] <= cell_key[1]))
    else $error("head key is larger than its neighbor");

  a_pop_counts_down : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("a pop did not lower the count by one");

endmodule
